// ===== rtl/dhfk_pkg.sv =====
// Shared types, constants and tables of the DH forward kinematics chain.
package dhfk_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int ROT_FRAC_DEF     = 30;

   localparam int DEG_W   = 17;
   localparam int LEN_W   = 25;
   localparam int TWIST_W = 19;
   localparam int ANG_W   = 15;
   localparam int CORD_W  = 34;
   localparam int OP_W    = 32;
   localparam int PROD_W  = 64;
   localparam int PROJ_W  = 26;
   localparam int ROT_W   = 32;
   localparam int POS_W   = 28;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [35:0] RAD_MUL = 36'sd9595049035;

   localparam logic signed [17:0] DEG_FULL    = 18'sd46080;
   localparam logic signed [17:0] DEG_HALF    = 18'sd23040;
   localparam logic signed [17:0] DEG_QUARTER = 18'sd11520;
   localparam logic signed [17:0] DEG_WRAP2   = 18'sd92160;
   localparam logic signed [17:0] DEG_EDGE2   = 18'sd69120;
   localparam logic signed [17:0] DEG_EDGE3   = 18'sd115200;

   localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;

   localparam logic signed [PROD_W-1:0] POS_LIMIT = 64'sd67108864;

   localparam logic signed [CORD_W-1:0] ATAN_HEAD [11] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
      34'sd4194283, 34'sd2097149, 34'sd1048576
   };

   typedef struct packed {
      logic signed [CORD_W-1:0] theta;
      logic                     neg_cos_theta;
      logic signed [CORD_W-1:0] alpha;
      logic                     neg_cos_alpha;
      logic signed [LEN_W-1:0]  len;
      logic signed [LEN_W-1:0]  off;
      logic                     last;
   } dhfk_job_type;

   function automatic logic signed [CORD_W-1:0] atan_entry(input logic [5:0] idx);
      logic signed [CORD_W-1:0] val;
      if (idx < 6'd11) begin
         val = ATAN_HEAD[idx[3:0]];
      end else if (idx <= 6'd30) begin
         val = 34'sd1 <<< (6'd30 - idx);
      end else begin
         val = '0;
      end
      return val;
   endfunction

endpackage

// ===== rtl/dhfk_front.sv =====
// Front end: accepts joint beats, folds the angles and converts degrees to radians.
module dhfk_front import dhfk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DEG_W-1:0]   req_joint_angle,
   input  logic signed [DEG_W-1:0]   req_angle_offset,
   input  logic signed [LEN_W-1:0]   req_link_length,
   input  logic signed [TWIST_W-1:0] req_link_twist,
   input  logic signed [LEN_W-1:0]   req_link_offset,
   input  logic                      req_last_joint,
   output logic                      job_valid,
   input  logic                      job_ready,
   output dhfk_job_type              job
);

   logic signed [17:0] ang_sum, ang_wrap, ang_fold;
   logic               neg_t;
   logic signed [34:0] tw_full, tw_wrap, tw_fold;
   logic               neg_a;
   logic signed [50:0] rad_full;
   logic               accept, push;

   logic                     vld_ff;
   logic signed [ANG_W-1:0]  ang_ff;
   logic                     negt_ff, nega_ff, last_ff;
   logic signed [CORD_W-1:0] tw_ff;
   logic signed [LEN_W-1:0]  len_ff, off_ff;
   logic                     vld_in;

   always_comb begin
      ang_sum = 18'(req_joint_angle) + 18'(req_angle_offset);
      if (ang_sum >= DEG_EDGE3) begin
         ang_wrap = ang_sum - DEG_WRAP2 - DEG_FULL;
      end else if (ang_sum >= DEG_EDGE2) begin
         ang_wrap = ang_sum - DEG_WRAP2;
      end else if (ang_sum >= DEG_HALF) begin
         ang_wrap = ang_sum - DEG_FULL;
      end else if (ang_sum < -DEG_EDGE3) begin
         ang_wrap = ang_sum + DEG_WRAP2 + DEG_FULL;
      end else if (ang_sum < -DEG_EDGE2) begin
         ang_wrap = ang_sum + DEG_WRAP2;
      end else if (ang_sum < -DEG_HALF) begin
         ang_wrap = ang_sum + DEG_FULL;
      end else begin
         ang_wrap = ang_sum;
      end
      neg_t = 1'b0;
      ang_fold = ang_wrap;
      if (ang_wrap > DEG_QUARTER) begin
         ang_fold = DEG_HALF - ang_wrap;
         neg_t = 1'b1;
      end else if (ang_wrap < -DEG_QUARTER) begin
         ang_fold = -DEG_HALF - ang_wrap;
         neg_t = 1'b1;
      end

      tw_full = 35'(req_link_twist) <<< 14;
      tw_wrap = tw_full;
      if (tw_wrap > PI_Q30) begin
         tw_wrap = tw_wrap - TWO_PI_Q30;
      end
      if (tw_wrap < -PI_Q30) begin
         tw_wrap = tw_wrap + TWO_PI_Q30;
      end
      neg_a = 1'b0;
      tw_fold = tw_wrap;
      if (tw_wrap > HALF_PI_Q30) begin
         tw_fold = PI_Q30 - tw_wrap;
         neg_a = 1'b1;
      end else if (tw_wrap < -HALF_PI_Q30) begin
         tw_fold = -PI_Q30 - tw_wrap;
         neg_a = 1'b1;
      end
   end

   assign push      = vld_ff && job_ready;
   assign req_stall = vld_ff && !job_ready;
   assign accept    = req_valid && !req_stall;
   assign vld_in    = accept ? 1'b1 : (push ? 1'b0 : vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         ang_ff  <= ANG_W'(ang_fold);
         negt_ff <= neg_t;
         tw_ff   <= CORD_W'(tw_fold);
         nega_ff <= neg_a;
         len_ff  <= req_link_length;
         off_ff  <= req_link_offset;
         last_ff <= req_last_joint;
      end
   end

   assign rad_full = 51'(ang_ff) * 51'(RAD_MUL) + 51'sd32768;

   always_comb begin
      job.theta         = CORD_W'(rad_full >>> 16);
      job.neg_cos_theta = negt_ff;
      job.alpha         = tw_ff;
      job.neg_cos_alpha = nega_ff;
      job.len           = len_ff;
      job.off           = off_ff;
      job.last          = last_ff;
   end

   assign job_valid = vld_ff;

endmodule

// ===== rtl/dhfk_queue.sv =====
// Two-entry job queue between the front end and the transform engine.
module dhfk_queue import dhfk_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  dhfk_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_take,
   output dhfk_job_type pop_job
);

   dhfk_job_type mem_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign push_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_take && pop_valid;
   assign pop_job    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("Queue pointers disagree with the count.");

endmodule

// ===== rtl/dhfk_back.sv =====
// Transform engine: CORDIC sine and cosine, shared multiplier and the transform store.
module dhfk_back import dhfk_pkg::*; #(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int ROT_FRAC_BITS = ROT_FRAC_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_take,
   input  dhfk_job_type            job,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [ROT_W-1:0] rot [9],
   output logic signed [POS_W-1:0] pos [3]
);

   localparam int RW     = ROT_FRAC_BITS + 2;
   localparam int CSH    = 30 - ROT_FRAC_BITS;
   localparam int CNT_W  = $clog2(CORDIC_STEPS);
   localparam logic signed [CORD_W-1:0] CORD_ONE  = 34'sd1 <<< ROT_FRAC_BITS;
   localparam logic signed [CORD_W-1:0] CORD_HALF =
      (CSH == 0) ? 34'sd0 : (34'sd1 <<< (CSH - 1));
   localparam logic signed [PROD_W-1:0] PROD_ONE  = 64'sd1 <<< ROT_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] PROD_HALF = 64'sd1 <<< (ROT_FRAC_BITS - 1);
   localparam logic signed [RW-1:0]     RW_ONE    = RW'(PROD_ONE);
   localparam logic [CNT_W-1:0]         CNT_LAST  = CNT_W'(CORDIC_STEPS - 1);

   localparam logic [2:0] PRE_ST_CA = 3'd0;
   localparam logic [2:0] PRE_ST_SA = 3'd1;
   localparam logic [2:0] PRE_CT_CA = 3'd2;
   localparam logic [2:0] PRE_CT_SA = 3'd3;
   localparam logic [2:0] PRE_A_CT  = 3'd4;
   localparam logic [2:0] PRE_A_ST  = 3'd5;
   localparam logic [2:0] PRE_NOP   = 3'd6;
   localparam logic [1:0] COL_POS   = 2'd3;
   localparam logic [1:0] LAST_ROW  = 2'd2;
   localparam logic [1:0] LAST_TERM = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CORD, ST_SCALE, ST_MAC, ST_DRAIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic       pre;
      logic [2:0] pidx;
      logic [1:0] row;
      logic [1:0] col;
   } dhfk_tag_type;

   state_type state_ff, state_in;

   logic signed [CORD_W-1:0] x0_ff, y0_ff, z0_ff, x1_ff, y1_ff, z1_ff;
   logic signed [CORD_W-1:0] x0_in, y0_in, z0_in, x1_in, y1_in, z1_in;
   logic signed [CORD_W-1:0] atn;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     negt_ff, nega_ff, last_ff;
   logic signed [LEN_W-1:0]  a_ff, d_ff;

   logic signed [RW-1:0]     ct_ff, st_ff, ca_ff, sa_ff;
   logic signed [RW-1:0]     t1_ff, t2_ff, t4_ff, t5_ff;
   logic signed [PROJ_W-1:0] p0_ff, p1_ff;
   logic signed [RW-1:0]     tmat [9];
   logic signed [PROJ_W-1:0] pvec [3];

   logic signed [RW-1:0]     orient_ff [9];
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [RW-1:0]     nrot_ff [9];
   logic signed [POS_W-1:0]  npos_ff [3];

   logic [2:0]               pre_ff;
   logic                     row_phase_ff;
   logic [1:0]               row_ff, col_ff, term_ff;
   logic [3:0]               ridx, tidx, widx;
   logic                     mac_end;

   logic signed [OP_W-1:0]   op_a, op_b;
   dhfk_tag_type             iss, tag_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic signed [PROD_W-1:0] wb_sum, wb_rnd, wb_pos;
   logic signed [RW-1:0]     wb_rot;
   logic signed [POS_W-1:0]  wb_posc;

   logic                     rsp_vld_ff, out_free, rsp_load;
   logic signed [ROT_W-1:0]  rot_ff [9];
   logic signed [POS_W-1:0]  pout_ff [3];

   function automatic logic signed [RW-1:0] cord_out(input logic signed [CORD_W-1:0] v,
                                                     input logic neg);
      logic signed [CORD_W-1:0] r;
      logic signed [RW-1:0]     c;
      r = (v + CORD_HALF) >>> CSH;
      if (r > CORD_ONE) begin
         c = RW'(CORD_ONE);
      end else if (r < -CORD_ONE) begin
         c = -RW'(CORD_ONE);
      end else begin
         c = RW'(r);
      end
      return neg ? -c : c;
   endfunction

   assign job_take = (state_ff == ST_IDLE) && job_valid;
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_DONE) && last_ff && out_free;
   assign mac_end  = row_phase_ff && (term_ff == LAST_TERM) && (col_ff == COL_POS) &&
                     (row_ff == LAST_ROW);

   always_comb begin
      atn = atan_entry(6'(cnt_ff));
      if (z0_ff >= 0) begin
         x0_in = x0_ff - (y0_ff >>> cnt_ff);
         y0_in = y0_ff + (x0_ff >>> cnt_ff);
         z0_in = z0_ff - atn;
      end else begin
         x0_in = x0_ff + (y0_ff >>> cnt_ff);
         y0_in = y0_ff - (x0_ff >>> cnt_ff);
         z0_in = z0_ff + atn;
      end
      if (z1_ff >= 0) begin
         x1_in = x1_ff - (y1_ff >>> cnt_ff);
         y1_in = y1_ff + (x1_ff >>> cnt_ff);
         z1_in = z1_ff - atn;
      end else begin
         x1_in = x1_ff + (y1_ff >>> cnt_ff);
         y1_in = y1_ff - (x1_ff >>> cnt_ff);
         z1_in = z1_ff + atn;
      end
   end

   always_comb begin
      tmat[0] = ct_ff;
      tmat[1] = t1_ff;
      tmat[2] = t2_ff;
      tmat[3] = st_ff;
      tmat[4] = t4_ff;
      tmat[5] = t5_ff;
      tmat[6] = '0;
      tmat[7] = sa_ff;
      tmat[8] = ca_ff;
      pvec[0] = p0_ff;
      pvec[1] = p1_ff;
      pvec[2] = PROJ_W'(d_ff);
   end

   assign ridx = 4'({2'b00, row_ff} * 4'd3 + {2'b00, term_ff});
   assign tidx = 4'({2'b00, term_ff} * 4'd3 + {2'b00, col_ff});
   assign widx = 4'({2'b00, tag_ff.row} * 4'd3 + {2'b00, tag_ff.col});

   always_comb begin
      op_a = '0;
      op_b = '0;
      iss  = '0;
      if (state_ff == ST_MAC) begin
         if (!row_phase_ff) begin
            iss.first = 1'b1;
            iss.last  = 1'b1;
            iss.pre   = 1'b1;
            iss.pidx  = pre_ff;
            iss.vld   = 1'b1;
            unique case (pre_ff)
               PRE_ST_CA: begin
                  op_a = OP_W'(st_ff);
                  op_b = OP_W'(ca_ff);
               end
               PRE_ST_SA: begin
                  op_a = OP_W'(st_ff);
                  op_b = OP_W'(sa_ff);
               end
               PRE_CT_CA: begin
                  op_a = OP_W'(ct_ff);
                  op_b = OP_W'(ca_ff);
               end
               PRE_CT_SA: begin
                  op_a = OP_W'(ct_ff);
                  op_b = OP_W'(sa_ff);
               end
               PRE_A_CT: begin
                  op_a = OP_W'(a_ff);
                  op_b = OP_W'(ct_ff);
               end
               PRE_A_ST: begin
                  op_a = OP_W'(a_ff);
                  op_b = OP_W'(st_ff);
               end
               default: begin
                  iss.vld = 1'b0;
               end
            endcase
         end else begin
            iss.vld   = 1'b1;
            iss.first = (term_ff == 2'd0);
            iss.last  = (term_ff == LAST_TERM);
            iss.row   = row_ff;
            iss.col   = col_ff;
            op_a      = OP_W'(orient_ff[ridx]);
            if (col_ff == COL_POS) begin
               op_b = OP_W'(pvec[term_ff]);
            end else begin
               op_b = OP_W'(tmat[tidx]);
            end
         end
      end
   end

   always_comb begin
      wb_sum = tag_ff.first ? prod_ff : acc_ff + prod_ff;
      wb_rnd = (wb_sum + PROD_HALF) >>> ROT_FRAC_BITS;
      wb_pos = wb_rnd + PROD_W'(pos_ff[tag_ff.row]);
      if (wb_rnd > PROD_ONE) begin
         wb_rot = RW_ONE;
      end else if (wb_rnd < -PROD_ONE) begin
         wb_rot = -RW_ONE;
      end else begin
         wb_rot = RW'(wb_rnd);
      end
      if (wb_pos > POS_LIMIT) begin
         wb_posc = POS_W'(POS_LIMIT);
      end else if (wb_pos < -POS_LIMIT) begin
         wb_posc = -POS_W'(POS_LIMIT);
      end else begin
         wb_posc = POS_W'(wb_pos);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_CORD;
            end
         end
         ST_CORD: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_MAC;
         end
         ST_MAC: begin
            if (mac_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!last_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         tag_ff     <= '0;
         for (int k = 0; k < 9; k++) begin
            orient_ff[k] <= (k == 0 || k == 4 || k == 8) ? RW_ONE : '0;
         end
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         tag_ff   <= iss;
         prod_ff  <= op_a * op_b;
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_vld_ff && !rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  x0_ff   <= CORDIC_GAIN;
                  y0_ff   <= '0;
                  z0_ff   <= job.theta;
                  x1_ff   <= CORDIC_GAIN;
                  y1_ff   <= '0;
                  z1_ff   <= job.alpha;
                  negt_ff <= job.neg_cos_theta;
                  nega_ff <= job.neg_cos_alpha;
                  a_ff    <= job.len;
                  d_ff    <= job.off;
                  last_ff <= job.last;
                  cnt_ff  <= '0;
               end
            end
            ST_CORD: begin
               x0_ff  <= x0_in;
               y0_ff  <= y0_in;
               z0_ff  <= z0_in;
               x1_ff  <= x1_in;
               y1_ff  <= y1_in;
               z1_ff  <= z1_in;
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_SCALE: begin
               ct_ff        <= cord_out(x0_ff, negt_ff);
               st_ff        <= cord_out(y0_ff, 1'b0);
               ca_ff        <= cord_out(x1_ff, nega_ff);
               sa_ff        <= cord_out(y1_ff, 1'b0);
               pre_ff       <= PRE_ST_CA;
               row_phase_ff <= 1'b0;
               row_ff       <= '0;
               col_ff       <= '0;
               term_ff      <= '0;
            end
            ST_MAC: begin
               if (!row_phase_ff) begin
                  if (pre_ff == PRE_NOP) begin
                     row_phase_ff <= 1'b1;
                  end else begin
                     pre_ff <= pre_ff + 3'd1;
                  end
               end else if (term_ff == LAST_TERM) begin
                  term_ff <= '0;
                  if (col_ff == COL_POS) begin
                     col_ff <= '0;
                     row_ff <= row_ff + 2'd1;
                  end else begin
                     col_ff <= col_ff + 2'd1;
                  end
               end else begin
                  term_ff <= term_ff + 2'd1;
               end
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
               if (!last_ff) begin
                  orient_ff <= nrot_ff;
                  pos_ff    <= npos_ff;
               end else if (out_free) begin
                  for (int k = 0; k < 9; k++) begin
                     rot_ff[k]    <= ROT_W'(nrot_ff[k]) <<< CSH;
                     orient_ff[k] <= (k == 0 || k == 4 || k == 8) ? RW_ONE : '0;
                  end
                  for (int k = 0; k < 3; k++) begin
                     pout_ff[k] <= npos_ff[k];
                     pos_ff[k]  <= '0;
                  end
               end
            end
            default: begin
            end
         endcase

         if (tag_ff.vld) begin
            acc_ff <= wb_sum;
            if (tag_ff.last) begin
               if (tag_ff.pre) begin
                  case (tag_ff.pidx)
                     PRE_ST_CA: t1_ff <= -RW'(wb_rnd);
                     PRE_ST_SA: t2_ff <= RW'(wb_rnd);
                     PRE_CT_CA: t4_ff <= RW'(wb_rnd);
                     PRE_CT_SA: t5_ff <= -RW'(wb_rnd);
                     PRE_A_CT:  p0_ff <= PROJ_W'(wb_rnd);
                     PRE_A_ST:  p1_ff <= PROJ_W'(wb_rnd);
                     default: begin
                     end
                  endcase
               end else if (tag_ff.col == COL_POS) begin
                  npos_ff[tag_ff.row] <= wb_posc;
               end else begin
                  nrot_ff[widx] <= wb_rot;
               end
            end
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rot       = rot_ff;
   assign pos       = pout_ff;

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && last_ff && out_free) |=>
      (pos_ff[0] == '0 && pos_ff[1] == '0 && pos_ff[2] == '0 && orient_ff[0] == RW_ONE))
      else $error("Transform store not returned to identity after a result.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("Result raised outside the completion step.");

   a_tag_in_mac: assert property (@(posedge clock) disable iff (reset)
      tag_ff.vld |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("Multiplier writeback outside the multiply phase.");

endmodule

// ===== rtl/dh_forward_kinematics_chain.sv =====
// Top level of the DH forward kinematics chain.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  one joint: angles, link length, twist, offset
//   rsp      out        rsp_valid/rsp_stall  nine rotation entries and three positions
//
// The front end registers each joint and hands it to a two-entry queue.
// The engine takes one job at a time and, per joint, runs CORDIC_STEPS iterations
// of two parallel CORDIC units, then drives the one shared 32x32 multiplier that
// builds the link transform and multiplies it in.
// Reset is synchronous and puts the stored transform back to identity.
// A stalled result holds in the output register while the next joint is processed.
module dh_forward_kinematics_chain import dhfk_pkg::*; #(
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int ROT_FRAC_BITS = ROT_FRAC_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DEG_W-1:0]   req_joint_angle,
   input  logic signed [DEG_W-1:0]   req_angle_offset,
   input  logic signed [LEN_W-1:0]   req_link_length,
   input  logic signed [TWIST_W-1:0] req_link_twist,
   input  logic signed [LEN_W-1:0]   req_link_offset,
   input  logic                      req_last_joint,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ROT_W-1:0]   rsp_rot_00,
   output logic signed [ROT_W-1:0]   rsp_rot_01,
   output logic signed [ROT_W-1:0]   rsp_rot_02,
   output logic signed [ROT_W-1:0]   rsp_rot_10,
   output logic signed [ROT_W-1:0]   rsp_rot_11,
   output logic signed [ROT_W-1:0]   rsp_rot_12,
   output logic signed [ROT_W-1:0]   rsp_rot_20,
   output logic signed [ROT_W-1:0]   rsp_rot_21,
   output logic signed [ROT_W-1:0]   rsp_rot_22,
   output logic signed [POS_W-1:0]   rsp_pos_x,
   output logic signed [POS_W-1:0]   rsp_pos_y,
   output logic signed [POS_W-1:0]   rsp_pos_z
);

   dhfk_job_type            f_job, q_job;
   logic                    f_valid, f_ready, q_valid, q_take;
   logic signed [ROT_W-1:0] rot [9];
   logic signed [POS_W-1:0] pos [3];

   dhfk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_joint_angle  (req_joint_angle),
      .req_angle_offset (req_angle_offset),
      .req_link_length  (req_link_length),
      .req_link_twist   (req_link_twist),
      .req_link_offset  (req_link_offset),
      .req_last_joint   (req_last_joint),
      .job_valid        (f_valid),
      .job_ready        (f_ready),
      .job              (f_job)
   );

   dhfk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (q_valid),
      .pop_take   (q_take),
      .pop_job    (q_job)
   );

   dhfk_back #(
      .CORDIC_STEPS  (CORDIC_STEPS),
      .ROT_FRAC_BITS (ROT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_take  (q_take),
      .job       (q_job),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rot       (rot),
      .pos       (pos)
   );

   assign rsp_rot_00 = rot[0];
   assign rsp_rot_01 = rot[1];
   assign rsp_rot_02 = rot[2];
   assign rsp_rot_10 = rot[3];
   assign rsp_rot_11 = rot[4];
   assign rsp_rot_12 = rot[5];
   assign rsp_rot_20 = rot[6];
   assign rsp_rot_21 = rot[7];
   assign rsp_rot_22 = rot[8];
   assign rsp_pos_x  = pos[0];
   assign rsp_pos_y  = pos[1];
   assign rsp_pos_z  = pos[2];

endmodule
